/* src/assert_macros.svh */
// assertion macros used by the rtl core
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/dfscc_pkg.sv */
// package for the dfs connected components core: field widths, command codes,
// parameter defaults; no dependencies
package dfscc_pkg;

   localparam int CMD_W       = 2;
   localparam int VTX_W       = 6;
   localparam int COMP_W      = 6;
   localparam int VCNT_W      = 7;
   localparam int REQ_W       = 16;
   localparam int RSP_W       = 24;
   localparam int FIELD_LIMIT = 64;   // vertex fields are six bits wide
   localparam int MAX_V_DEF   = 64;
   localparam int MAX_DEG_DEF = 8;

   localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

endpackage

/* src/dfs_connected_components_core.sv */
// dfs connected components core: clear in idle, append reads list count then writes back
// run: root scan, step and check per edge, count load per vertex, row read per result,
// set by the single read port of each state memory; one transaction in flight at a time;
// results leave through an output register, the next loaded once rsp_tready takes the one
// before; reset (synchronous, active high) clears all adjacency lists at once through count
// valid bits, no clearing pass; vertex_count resets to 64, overflow flag to zero
`include "assert_macros.svh"

module dfs_connected_components_core
   import dfscc_pkg::*;
#(
   parameter int MAX_V   = MAX_V_DEF,
   parameter int MAX_DEG = MAX_DEG_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request transactions
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // from_vertex[5:0], to_vertex[11:6], zero
   input  logic [CMD_W-1:0]  req_tuser,   // cmd[1:0]
   // result transactions
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // vertex_index[5:0], component[11:6],
                                          // parent_vertex[17:12], has_parent[18],
                                          // overflow[19], zero
   output logic              rsp_tlast,
   // vertex_count register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [VCNT_W-1:0] csr_data
);

   // only vertices a six bit field can name are ever stored
   localparam int VCAP = (MAX_V < FIELD_LIMIT) ? MAX_V : FIELD_LIMIT;
   localparam int VW   = $clog2(VCAP);          // vertex index into the stores
   localparam int NW   = $clog2(VCAP + 1);      // counts 0..VCAP
   localparam int DW   = $clog2(MAX_DEG + 1);   // edge counts 0..MAX_DEG
   localparam int SD   = VCAP * MAX_DEG;        // neighbor store depth
   localparam int AW   = $clog2(SD);
   localparam int SKW  = VW + 2 * DW;           // stack entry: vertex, next edge, count

   localparam logic [VTX_W:0]  VCAP_V  = (VTX_W + 1)'(VCAP);
   localparam logic [DW-1:0]   DEG_MAX = DW'(MAX_DEG);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,     // count of from_vertex arrives, append or flag overflow
      ST_SCAN,       // outer loop over root candidates
      ST_LOADCNT,    // edge count of the new top vertex arrives
      ST_STEP,       // next edge of top, or pop
      ST_POP,        // popped stack entry arrives
      ST_CHECK,      // neighbor arrives, visit and push if new
      ST_EMIT_LD,    // result row arrives, load output register
      ST_EMIT_WAIT   // result held until taken
   } state_type;

   // ---------------------------------------------------------------------
   // request fields
   // ---------------------------------------------------------------------
   logic [CMD_W-1:0] req_cmd;
   logic [VTX_W-1:0] req_from;
   logic [VTX_W-1:0] req_to;

   assign req_cmd  = req_tuser;
   assign req_from = req_tdata[VTX_W-1:0];
   assign req_to   = req_tdata[VTX_W +: VTX_W];

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   state_type         state_ff,     state_in;
   logic [VCNT_W-1:0] vcnt_ff,      vcnt_in;
   logic              ovf_ff,       ovf_in;
   logic [VCAP-1:0]   cnt_vld_ff,   cnt_vld_in;   // list holds entries since last clear
   logic [VCAP-1:0]   visited_ff,   visited_in;
   logic [VCAP-1:0]   hp_ff,        hp_in;        // vertex has a parent
   logic [NW-1:0]     n_ff,         n_in;         // effective vertex count of this run
   logic [NW-1:0]     scan_ff,      scan_in;
   logic [NW-1:0]     depth_ff,     depth_in;     // stack entries including the top
   logic [NW-1:0]     next_comp_ff, next_comp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   // payload
   logic [VW-1:0]     from_ff,      from_in;
   logic [VW-1:0]     to_ff,        to_in;
   logic [VW-1:0]     top_u_ff,     top_u_in;
   logic [DW-1:0]     top_e_ff,     top_e_in;
   logic [DW-1:0]     top_c_ff,     top_c_in;
   logic [COMP_W-1:0] cur_comp_ff,  cur_comp_in;
   logic [VW-1:0]     emit_ff,      emit_in;
   logic [RSP_W-1:0]  rsp_data_ff,  rsp_data_in;
   logic              rsp_last_ff,  rsp_last_in;

   // ---------------------------------------------------------------------
   // memories, one read and one write port each, registered read data;
   // the sequencer never uses read data of an entry read in the cycle it is written
   // ---------------------------------------------------------------------
   logic [VTX_W-1:0]  nbr_mem   [SD];     // adjacency lists, row per vertex
   logic [DW-1:0]     cnt_mem   [VCAP];   // list length, valid through cnt_vld_ff
   logic [COMP_W-1:0] comp_mem  [VCAP];
   logic [VW-1:0]     par_mem   [VCAP];
   logic [SKW-1:0]    stk_mem   [VCAP];   // entries below the top

   logic              nbr_we;
   logic [AW-1:0]     nbr_waddr, nbr_raddr;
   logic [VTX_W-1:0]  nbr_wdata, nbr_rdata_ff;

   logic              cnt_we;
   logic [VW-1:0]     cnt_waddr, cnt_raddr;
   logic [DW-1:0]     cnt_wdata, cnt_rdata_ff;

   logic              comp_we, par_we;
   logic [VW-1:0]     row_waddr, row_raddr;
   logic [COMP_W-1:0] comp_wdata, comp_rdata_ff;
   logic [VW-1:0]     par_wdata, par_rdata_ff;

   logic              stk_we;
   logic [VW-1:0]     stk_waddr, stk_raddr;
   logic [SKW-1:0]    stk_rdata_ff;

   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem[nbr_waddr] <= nbr_wdata;
      end
      nbr_rdata_ff <= nbr_mem[nbr_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (comp_we) begin
         comp_mem[row_waddr] <= comp_wdata;
      end
      comp_rdata_ff <= comp_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[row_waddr] <= par_wdata;
      end
      par_rdata_ff <= par_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= {top_u_ff, top_e_ff, top_c_ff};
      end
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   logic              req_fire;
   logic [DW-1:0]     app_cnt;     // current length of the list being appended to
   logic [VTX_W-1:0]  nbr_v;       // neighbor read from the store
   logic              push;        // neighbor is in range and new
   logic [VW-1:0]     scan_idx;

   assign req_fire = req_tvalid && req_tready;
   assign app_cnt  = cnt_vld_ff[from_ff] ? cnt_rdata_ff : '0;
   assign nbr_v    = nbr_rdata_ff;
   assign push     = ({1'b0, nbr_v} < (VTX_W + 1)'(n_ff)) && !visited_ff[nbr_v[VW-1:0]];
   assign scan_idx = scan_ff[VW-1:0];

   always_comb begin
      state_in     = state_ff;
      vcnt_in      = csr_valid ? csr_data : vcnt_ff;
      ovf_in       = ovf_ff;
      cnt_vld_in   = cnt_vld_ff;
      visited_in   = visited_ff;
      hp_in        = hp_ff;
      n_in         = n_ff;
      scan_in      = scan_ff;
      depth_in     = depth_ff;
      next_comp_in = next_comp_ff;
      rsp_valid_in = rsp_valid_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      top_u_in     = top_u_ff;
      top_e_in     = top_e_ff;
      top_c_in     = top_c_ff;
      cur_comp_in  = cur_comp_ff;
      emit_in      = emit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      nbr_we     = 1'b0;
      nbr_waddr  = AW'(AW'(from_ff) * AW'(MAX_DEG) + AW'(app_cnt));
      nbr_wdata  = VTX_W'(to_ff);
      nbr_raddr  = AW'(AW'(top_u_ff) * AW'(MAX_DEG) + AW'(top_e_ff));
      cnt_we     = 1'b0;
      cnt_waddr  = from_ff;
      cnt_wdata  = DW'(app_cnt + 1'b1);
      cnt_raddr  = scan_idx;
      comp_we    = 1'b0;
      par_we     = 1'b0;
      row_waddr  = nbr_v[VW-1:0];
      comp_wdata = cur_comp_ff;
      par_wdata  = top_u_ff;
      row_raddr  = '0;
      stk_we     = 1'b0;
      stk_waddr  = VW'(depth_ff - 1'b1);
      stk_raddr  = VW'(depth_ff - 2'd2);

      unique case (state_ff)
         ST_IDLE: begin
            cnt_raddr = req_from[VW-1:0];
            if (req_fire) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     cnt_vld_in = '0;
                     ovf_in     = 1'b0;
                  end
                  CMD_APPEND: begin
                     // edges naming a vertex beyond the store are ignored
                     if (({1'b0, req_from} < VCAP_V) && ({1'b0, req_to} < VCAP_V)) begin
                        from_in  = req_from[VW-1:0];
                        to_in    = req_to[VW-1:0];
                        state_in = ST_APPEND;
                     end
                  end
                  CMD_RUN: begin
                     n_in         = (vcnt_ff > VCNT_W'(VCAP)) ? NW'(VCAP) : NW'(vcnt_ff);
                     visited_in   = '0;
                     hp_in        = '0;
                     scan_in      = '0;
                     depth_in     = '0;
                     next_comp_in = '0;
                     // a zero vertex count gives an empty run
                     if (vcnt_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_APPEND: begin
            if (app_cnt < DEG_MAX) begin
               nbr_we              = 1'b1;
               cnt_we              = 1'b1;
               cnt_vld_in[from_ff] = 1'b1;
            end else begin
               ovf_in = 1'b1;   // full list, edge dropped
            end
            state_in = ST_IDLE;
         end

         ST_SCAN: begin
            row_waddr = scan_idx;
            if (scan_ff == n_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT_LD;
            end else if (visited_ff[scan_idx]) begin
               scan_in = NW'(scan_ff + 1'b1);
            end else begin
               // new root opens the next component
               visited_in[scan_idx] = 1'b1;
               comp_we              = 1'b1;
               comp_wdata           = COMP_W'(next_comp_ff);
               cur_comp_in          = COMP_W'(next_comp_ff);
               next_comp_in         = NW'(next_comp_ff + 1'b1);
               top_u_in             = scan_idx;
               top_e_in             = '0;
               depth_in             = NW'(1);
               state_in             = ST_LOADCNT;
            end
         end

         ST_LOADCNT: begin
            top_c_in = cnt_vld_ff[top_u_ff] ? cnt_rdata_ff : '0;
            state_in = ST_STEP;
         end

         ST_STEP: begin
            if (top_e_ff < top_c_ff) begin
               top_e_in = DW'(top_e_ff + 1'b1);
               state_in = ST_CHECK;
            end else if (depth_ff == NW'(1)) begin
               depth_in = '0;
               scan_in  = NW'(scan_ff + 1'b1);
               state_in = ST_SCAN;
            end else begin
               depth_in = NW'(depth_ff - 1'b1);
               state_in = ST_POP;
            end
         end

         ST_POP: begin
            top_u_in = stk_rdata_ff[SKW-1 -: VW];
            top_e_in = stk_rdata_ff[2*DW-1 -: DW];
            top_c_in = stk_rdata_ff[DW-1:0];
            state_in = ST_STEP;
         end

         ST_CHECK: begin
            cnt_raddr = nbr_v[VW-1:0];
            if (push) begin
               visited_in[nbr_v[VW-1:0]] = 1'b1;
               hp_in[nbr_v[VW-1:0]]      = 1'b1;
               comp_we  = 1'b1;
               par_we   = 1'b1;
               stk_we   = 1'b1;
               top_u_in = nbr_v[VW-1:0];
               top_e_in = '0;
               depth_in = NW'(depth_ff + 1'b1);
               state_in = ST_LOADCNT;
            end else begin
               state_in = ST_STEP;
            end
         end

         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = RSP_W'({ovf_ff,
                                   hp_ff[emit_ff],
                                   hp_ff[emit_ff] ? VTX_W'(par_rdata_ff) : VTX_W'(0),
                                   comp_rdata_ff,
                                   VTX_W'(emit_ff)});
            rsp_last_in  = (NW'(emit_ff) == NW'(n_ff - 1'b1));
            state_in     = ST_EMIT_WAIT;
         end

         ST_EMIT_WAIT: begin
            row_raddr = VW'(emit_ff + 1'b1);
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = VW'(emit_ff + 1'b1);
                  state_in = ST_EMIT_LD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= VCNT_RESET;
         ovf_ff       <= 1'b0;
         cnt_vld_ff   <= '0;
         visited_ff   <= '0;
         hp_ff        <= '0;
         n_ff         <= '0;
         scan_ff      <= '0;
         depth_ff     <= '0;
         next_comp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         ovf_ff       <= ovf_in;
         cnt_vld_ff   <= cnt_vld_in;
         visited_ff   <= visited_in;
         hp_ff        <= hp_in;
         n_ff         <= n_in;
         scan_ff      <= scan_in;
         depth_ff     <= depth_in;
         next_comp_ff <= next_comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      from_ff     <= from_in;
      to_ff       <= to_in;
      top_u_ff    <= top_u_in;
      top_e_ff    <= top_e_in;
      top_c_ff    <= top_c_in;
      cur_comp_ff <= cur_comp_in;
      emit_ff     <= emit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, depth_ff <= n_ff, "stack deeper than run")
   `ASSERT_SAME(a_idle_empty, clock, reset, req_tready, depth_ff == '0, "idle with stack entries")
   `ASSERT_SAME(a_last_index, clock, reset, rsp_tvalid && rsp_tlast,
                rsp_tdata[VTX_W-1:0] == VTX_W'(n_ff - 1'b1), "last flag on wrong vertex")
   `ASSERT_NEXT(a_push_marks, clock, reset, (state_ff == ST_CHECK) && push,
                visited_ff[top_u_ff] && (state_ff == ST_LOADCNT), "pushed vertex not visited")

endmodule

/* verif/dfs_connected_components_core_tb.sv */
// self-checking testbench for the dfs connected components core: edge loads, clears and
// search runs on streaming request/result channels, checked against an in-bench search
// depends on dfscc_pkg and dfs_connected_components_core
module dfs_connected_components_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dfscc_pkg::*;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 64;          // covers append and empty-run latency
   localparam int LONG_HOLD     = 500;         // receiver hold-off for the fill-up test
   localparam int MAX_REPORTS   = 10;
   localparam longint TIMEOUT_NS = 8_000_000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // one expected result: the labels of a single vertex
   typedef struct {
      logic [VTX_W-1:0]  vertex;
      logic [COMP_W-1:0] component;
      logic [VTX_W-1:0]  parent;
      logic              has_parent;
      logic              overflow;
      logic              last;
   } vertex_label_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]  req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [VCNT_W-1:0] csr_data = '0;

   // mirror of the block's adjacency lists and search settings
   logic [VTX_W-1:0]  adj_list [MAX_V_DEF][MAX_DEG_DEF];
   int unsigned       adj_len [MAX_V_DEF];
   logic              edge_dropped;
   logic [VCNT_W-1:0] vertex_count_now;

   vertex_label_type  pending_labels[$];

   // idle rates in percent and the long hold-off request
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_seq      = 0;   // bumped by the test to start a hold-off
   int hold_seen     = 0;
   int hold_left     = 0;

   int requests_sent  = 0;
   int runs_sent      = 0;
   int labels_checked = 0;
   int mismatch_count = 0;

   dfs_connected_components_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // search mirror: iterative depth-first scan with (vertex, next edge) stack entries
   // ---------------------------------------------------------------------------------------
   task automatic label_components();
      int               n;
      int               root;
      int               depth;
      int               next_id;
      int               u;
      int               e;
      int               v;
      bit               seen [MAX_V_DEF];
      int               comp_id [MAX_V_DEF];
      int               discovered_by [MAX_V_DEF];
      int               walk_vertex [MAX_V_DEF];
      int               walk_edge [MAX_V_DEF];
      vertex_label_type lbl;
      // counts above the vertex field range are clamped
      n = (vertex_count_now > MAX_V_DEF) ? MAX_V_DEF : int'(vertex_count_now);
      for (int i = 0; i < MAX_V_DEF; i++) begin
         seen[i] = 1'b0;
         comp_id[i] = 0;
         discovered_by[i] = -1;
      end
      next_id = 0;
      for (root = 0; root < n; root++) begin
         if (!seen[root]) begin
            seen[root] = 1'b1;
            comp_id[root] = next_id;
            next_id++;
            walk_vertex[0] = root;
            walk_edge[0] = 0;
            depth = 1;
            while (depth > 0) begin
               u = walk_vertex[depth-1];
               e = walk_edge[depth-1];
               if (e < adj_len[u]) begin
                  v = adj_list[u][e];
                  walk_edge[depth-1] = e + 1;
                  // neighbors at or past the active count are skipped
                  if (v < n && !seen[v]) begin
                     seen[v] = 1'b1;
                     discovered_by[v] = u;
                     comp_id[v] = comp_id[u];
                     walk_vertex[depth] = v;
                     walk_edge[depth] = 0;
                     depth++;
                  end
               end else begin
                  depth--;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         lbl.vertex     = i[VTX_W-1:0];
         lbl.component  = comp_id[i][COMP_W-1:0];
         lbl.has_parent = (discovered_by[i] >= 0);
         lbl.parent     = lbl.has_parent ? discovered_by[i][VTX_W-1:0] : '0;
         lbl.overflow   = edge_dropped;
         lbl.last       = (i == n - 1);
         pending_labels.push_back(lbl);
      end
   endtask

   // update the mirror for one accepted request
   task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] src,
                                input logic [VTX_W-1:0] dst);
      case (cmd)
         CMD_CLEAR: begin
            foreach (adj_len[i]) adj_len[i] = 0;
            edge_dropped = 1'b0;
         end
         CMD_APPEND: begin
            // a full list drops the edge and raises the sticky flag
            if (adj_len[src] < MAX_DEG_DEF) begin
               adj_list[src][adj_len[src]] = dst;
               adj_len[src]++;
            end else begin
               edge_dropped = 1'b1;
            end
         end
         CMD_RUN: begin
            label_components();
            runs_sent++;
         end
         default: ;   // unused code, no effect
      endcase
   endtask

   // ---------------------------------------------------------------------------------------
   // request side: one transaction per call, optional random gap in front of it
   // ---------------------------------------------------------------------------------------
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] src,
                               input logic [VTX_W-1:0] dst);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays high between back-to-back transactions, set only once per step
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, dst, src};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      apply_request(cmd, src, dst);
      requests_sent++;
   endtask

   // wait until every expected result is in, then let trailing work finish
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_vertex_count(input logic [VCNT_W-1:0] count);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      vertex_count_now = count;
   endtask

   function automatic logic [VTX_W-1:0] any_vertex(input int span);
      return VTX_W'($urandom_range(span - 1, 0));
   endfunction

   // ---------------------------------------------------------------------------------------
   // result side: random ready, plus a long hold-off on request
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      vertex_label_type want;
      vertex_label_type got;
      logic             wrong;
      if (!reset && rsp_tvalid && rsp_tready) begin
         labels_checked++;
         got.vertex     = rsp_tdata[5:0];
         got.component  = rsp_tdata[11:6];
         got.parent     = rsp_tdata[17:12];
         got.has_parent = rsp_tdata[18];
         got.overflow   = rsp_tdata[19];
         got.last       = rsp_tlast;
         if (pending_labels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result vertex=%0d comp=%0d parent=%0d", $realtime,
                        got.vertex, got.component, got.parent);
         end else begin
            want = pending_labels.pop_front();
            wrong = (got.vertex !== want.vertex) || (got.component !== want.component) ||
                    (got.parent !== want.parent) || (got.has_parent !== want.has_parent) ||
                    (got.overflow !== want.overflow) || (got.last !== want.last);
            if (wrong) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: expected vtx=%0d comp=%0d par=%0d hp=%0b ovf=%0b last=%0b",
                           $realtime, want.vertex, want.component, want.parent,
                           want.has_parent, want.overflow, want.last);
                  $display("%0t: actual   vtx=%0d comp=%0d par=%0d hp=%0b ovf=%0b last=%0b",
                           $realtime, got.vertex, got.component, got.parent,
                           got.has_parent, got.overflow, got.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // search right after reset: 64 isolated roots, then an unused command
   task automatic test_reset_state();
      send_request(CMD_RUN, '0, '0);
      send_request(CMD_UNUSED, '1, '1);
   endtask

   // small graph with a cycle, a self loop, a two-vertex pair and an edge past the count
   task automatic test_small_graph();
      write_vertex_count(7'd8);
      send_request(CMD_CLEAR, '0, '0);
      send_request(CMD_APPEND, 6'd0, 6'd1);
      send_request(CMD_APPEND, 6'd1, 6'd2);
      send_request(CMD_APPEND, 6'd2, 6'd0);
      send_request(CMD_APPEND, 6'd1, 6'd3);
      send_request(CMD_APPEND, 6'd3, 6'd3);
      send_request(CMD_APPEND, 6'd5, 6'd6);
      send_request(CMD_APPEND, 6'd4, 6'd40);   // beyond the active count, skipped
      send_request(CMD_RUN, '0, '0);
   endtask

   // fill the list of the top vertex and push one more edge to set the sticky flag
   task automatic test_full_list();
      write_vertex_count(7'd64);
      send_request(CMD_CLEAR, '0, '0);
      send_request(CMD_APPEND, 6'd63, 6'd63);
      for (int i = 0; i < MAX_DEG_DEF; i++)
         send_request(CMD_APPEND, 6'd63, i[VTX_W-1:0]);
      send_request(CMD_RUN, '0, '0);
   endtask

   // register extremes: empty run, clamped count, single vertex
   task automatic test_count_extremes();
      write_vertex_count(7'd0);
      send_request(CMD_RUN, '0, '0);
      write_vertex_count(7'd127);
      send_request(CMD_RUN, '0, '0);
      write_vertex_count(7'd1);
      send_request(CMD_RUN, '0, '0);
   endtask

   // random graphs: mostly clear, edges, run; some noise and stale lists left in place
   task automatic test_random_graphs(input int s_pct, input int r_pct, input int budget);
      int                counted;
      int                span;
      int                edge_total;
      int                pick;
      logic [VTX_W-1:0]  hub;
      logic [VCNT_W-1:0] count;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      counted = 0;
      while (counted < budget) begin
         // most searches are small so the run stays short, a few use the full range
         pick = $urandom_range(99);
         if (pick < 70)      count = VCNT_W'($urandom_range(16, 1));
         else if (pick < 85) count = VCNT_W'($urandom_range(63, 17));
         else if (pick < 93) count = 7'd64;
         else                count = VCNT_W'($urandom_range(127, 65));
         write_vertex_count(count);
         span = (count > MAX_V_DEF) ? MAX_V_DEF : int'(count);
         if ($urandom_range(99) < 85) begin
            send_request(CMD_CLEAR, any_vertex(64), any_vertex(64));
            counted++;
         end
         edge_total = $urandom_range((span * 2 > 24) ? 24 : span * 2, 0);
         hub = any_vertex(span);
         repeat (edge_total) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               send_request(CMD_UNUSED, any_vertex(64), any_vertex(64));
            end else begin
               if (pick < 75)      send_request(CMD_APPEND, any_vertex(span), any_vertex(span));
               else if (pick < 88) send_request(CMD_APPEND, any_vertex(64), any_vertex(64));
               else                send_request(CMD_APPEND, hub, any_vertex(span));  // fills a list
               counted++;
            end
         end
         send_request(CMD_RUN, any_vertex(64), any_vertex(64));
         counted++;
      end
   endtask

   // receiver holds off while requests keep coming, so the core must stall its input
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_vertex_count(7'd64);
      send_request(CMD_CLEAR, '0, '0);
      repeat (10) send_request(CMD_APPEND, any_vertex(64), any_vertex(64));
      hold_seq++;
      send_request(CMD_RUN, '0, '0);
      repeat (6) send_request(CMD_APPEND, any_vertex(64), any_vertex(64));
      send_request(CMD_RUN, '0, '0);
   endtask

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      foreach (adj_len[i]) adj_len[i] = 0;
      edge_dropped = 1'b0;
      vertex_count_now = VCNT_RESET;
      send_idle_pct = 32;
      recv_idle_pct = 65;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_small_graph();
      test_full_list();
      test_count_extremes();
      test_random_graphs(32, 65, 125);
      test_random_graphs(65, 32, 125);
      test_random_graphs(0, 0, 125);
      test_backpressure();
      drain_results();

      $display("run covered %0d requests with %0d searches and %0d vertex results checked",
               requests_sent, runs_sent, labels_checked);
      $display("vertex counts 0 to 127, full lists, stale lists, idle phases and a long stall");
      if (mismatch_count == 0 && pending_labels.size() == 0) begin
         $display("dfs_connected_components_core test passed");
      end else begin
         $display("%0d mismatches, %0d results still expected", mismatch_count,
                  pending_labels.size());
         $display("dfs_connected_components_core test failed");
      end
      $finish;
   end

   // watchdog against a hung handshake
   initial begin
      #TIMEOUT_NS;
      $display("timeout with %0d results still expected", pending_labels.size());
      $display("dfs_connected_components_core test failed");
      $finish;
   end

endmodule
